### sv/mse_pkg.sv
// ----------------------------------------------------------------------------
// mse_pkg
// Shared defaults for the merge sort engine and its buffer RAM.
// ----------------------------------------------------------------------------
package mse_pkg;

  localparam int CAPACITY_DEF   = 64;
  localparam int DATA_WIDTH_DEF = 32;

endpackage

### sv/mse_ram.sv
// ----------------------------------------------------------------------------
// mse_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module mse_ram #(
  parameter int WIDTH = mse_pkg::DATA_WIDTH_DEF,
  parameter int DEPTH = mse_pkg::CAPACITY_DEF,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

### sv/merge_sort_engine.sv
// ----------------------------------------------------------------------------
// merge_sort_engine
// Flow: load accepts one request per cycle while idle; the sort then runs
// ceil(log2 n) passes, each merge step paced by the single compare unit
// and the registered read of the source RAM; emit reads, loads and holds
// each result until out_ready, and no new batch is taken until emit ends.
// Reset (rst, synchronous) empties the batch and drops any sort in progress.
// ----------------------------------------------------------------------------
module merge_sort_engine #(
  parameter int CAPACITY   = mse_pkg::CAPACITY_DEF,
  parameter int DATA_WIDTH = mse_pkg::DATA_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [DATA_WIDTH-1:0] value,
  input  logic                         last,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [DATA_WIDTH-1:0] sorted_value,
  output logic                         last_res,
  output logic                         overflow
);

  import mse_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_PASS_INIT = 3'd1;
  localparam logic [2:0] S_RUN_INIT  = 3'd2;
  localparam logic [2:0] S_READ      = 3'd3;
  localparam logic [2:0] S_CMP       = 3'd4;
  localparam logic [2:0] S_EMIT_RD   = 3'd5;
  localparam logic [2:0] S_EMIT_LD   = 3'd6;
  localparam logic [2:0] S_EMIT_WAIT = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] count;
  logic          dropped;
  logic [CW-1:0] n;
  logic [CW:0]   width;
  logic [CW-1:0] lo, mid, hi, i, j, k, e;
  logic          src;

  logic                  ram0_we, ram1_we;
  logic [AW-1:0]         ram0_waddr, raddr_a, raddr_b;
  logic [DATA_WIDTH-1:0] ram0_wdata, merge_data;
  logic [DATA_WIDTH-1:0] ram0_rdata_a, ram0_rdata_b, ram1_rdata_a, ram1_rdata_b;
  logic [DATA_WIDTH-1:0] head_a, head_b;

  logic          in_accept, has_left, has_right, take, pick_left;
  logic [CW+1:0] mid_sum, hi_sum;

  assign in_ready  = (state == S_IDLE);
  assign in_accept = in_valid && in_ready;

  assign head_a = src ? ram1_rdata_a : ram0_rdata_a;
  assign head_b = src ? ram1_rdata_b : ram0_rdata_b;

  assign has_left  = (i < mid);
  assign has_right = (j < hi);
  assign take      = has_left || has_right;
  // Stable merge: left run wins ties.
  assign pick_left = has_left && (!has_right || ($signed(head_a) <= $signed(head_b)));
  assign merge_data = pick_left ? head_a : head_b;

  assign mid_sum = {2'b00, lo} + {1'b0, width};
  assign hi_sum  = {2'b00, lo} + {width, 1'b0};

  always_comb begin
    raddr_a = (state == S_EMIT_RD) ? e[AW-1:0] : i[AW-1:0];
    raddr_b = j[AW-1:0];
    ram1_we = (state == S_CMP) && take && !src;
    if (state == S_IDLE) begin
      ram0_we    = in_accept && (count < CW'(CAPACITY));
      ram0_waddr = count[AW-1:0];
      ram0_wdata = value;
    end else begin
      ram0_we    = (state == S_CMP) && take && src;
      ram0_waddr = k[AW-1:0];
      ram0_wdata = merge_data;
    end
  end

  mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_store (
    .clk     (clk),
    .we      (ram0_we),
    .waddr   (ram0_waddr),
    .wdata   (ram0_wdata),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ram0_rdata_a),
    .rdata_b (ram0_rdata_b)
  );

  mse_ram #(.WIDTH(DATA_WIDTH), .DEPTH(CAPACITY)) u_scratch (
    .clk     (clk),
    .we      (ram1_we),
    .waddr   (k[AW-1:0]),
    .wdata   (merge_data),
    .raddr_a (raddr_a),
    .raddr_b (raddr_b),
    .rdata_a (ram1_rdata_a),
    .rdata_b (ram1_rdata_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      dropped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            if (count < CW'(CAPACITY)) begin
              count <= count + 1'b1;
              n     <= count + 1'b1;
            end else begin
              dropped <= 1'b1;
              n       <= count;
            end
            if (last) begin
              width <= (CW+1)'(1);
              src   <= 1'b0;
              state <= S_PASS_INIT;
            end
          end
        end
        S_PASS_INIT: begin
          lo <= '0;
          k  <= '0;
          e  <= '0;
          if (width < {1'b0, n}) begin
            state <= S_RUN_INIT;
          end else begin
            state <= S_EMIT_RD;
          end
        end
        S_RUN_INIT: begin
          if (lo < n) begin
            mid   <= (mid_sum > (CW+2)'(n)) ? n : mid_sum[CW-1:0];
            hi    <= (hi_sum > (CW+2)'(n)) ? n : hi_sum[CW-1:0];
            i     <= lo;
            j     <= (mid_sum > (CW+2)'(n)) ? n : mid_sum[CW-1:0];
            state <= S_READ;
          end else begin
            // Pass done: swap source and destination.
            width <= {width[CW-1:0], 1'b0};
            src   <= !src;
            state <= S_PASS_INIT;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (take) begin
            k <= k + 1'b1;
            if (pick_left) begin
              i <= i + 1'b1;
            end else begin
              j <= j + 1'b1;
            end
            state <= S_READ;
          end else begin
            lo    <= hi;
            state <= S_RUN_INIT;
          end
        end
        S_EMIT_RD: begin
          state <= S_EMIT_LD;
        end
        S_EMIT_LD: begin
          sorted_value <= head_a;
          last_res     <= (e + 1'b1 == n);
          overflow     <= dropped;
          out_valid    <= 1'b1;
          e            <= e + 1'b1;
          state        <= S_EMIT_WAIT;
        end
        S_EMIT_WAIT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (last_res) begin
              count   <= '0;
              dropped <= 1'b0;
              state   <= S_IDLE;
            end else begin
              state <= S_EMIT_RD;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
